>>> rtl/core/l3dg_pkg.sv
// Shared types and constants for the 3D life generation engine.
package l3dg_pkg;

  localparam int OP_W    = 2;
  localparam int FRAME_W = 8;
  localparam int RATE_W  = 8;
  localparam int BITS_W  = 16;
  localparam int CNT_W   = 5;

  localparam logic [RATE_W-1:0] RATE_RESET = 8'd1;
  localparam logic [CNT_W-1:0]  BORN_CNT   = 5'd3;
  localparam logic [CNT_W-1:0]  KEEP_CNT   = 5'd2;

  // neighbor offset codes along y and z: below, same, above
  localparam logic [1:0] D_LO  = 2'd0;
  localparam logic [1:0] D_MID = 2'd1;
  localparam logic [1:0] D_HI  = 2'd2;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } l3dg_op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDATA,
    ST_MOD,
    ST_READ,
    ST_WAIT,
    ST_WRITE
  } l3dg_state_t;

  typedef struct packed {
    logic clear;
    logic acc;
    logic center;
    logic inr;
  } l3dg_lane_ctl_t;

endpackage

>>> rtl/core/life_3d_generation_engine_top.sv
// Top level of the 3D life generation engine: sequencer, grid banks and result port.
//
// Usage: present an item on in_* with start high; it is taken at an edge where
// busy is low. Operations: write row, read row, frame tick, no-op. Every item yields
// exactly one result: out_valid is high for one cycle with out_read_bits and
// out_stepped, and the receiver cannot stall it.
// A tick whose frame is a multiple of update_rate runs one generation: each
// of the LAYERS*ROWS_PER_LAYER rows is built by reading its nine neighbor rows
// through the single RAM read port into the shared count lanes, then the
// ST_WAIT drain and the ST_WRITE write-back. busy is high for the whole tick.
// The grid is double banked: a generation reads the live bank and writes the
// other, then swaps them.
// Reset: a clearing pass zeroes every row of the live bank, with busy high;
// cfg_wr_en writes update_rate at any time (reset value 1).
module life_3d_generation_engine_top #(
  parameter int CELLS_PER_ROW  = 16,
  parameter int ROWS_PER_LAYER = 16,
  parameter int LAYERS         = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [3:0]  in_layer,
  input  logic [3:0]  in_row,
  input  logic [15:0] in_row_bits,
  input  logic [7:0]  in_frame,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  output logic        out_valid,
  output logic [15:0] out_read_bits,
  output logic        out_stepped
);

  localparam int GRID = LAYERS * ROWS_PER_LAYER;
  localparam int AW   = $clog2(GRID);
  localparam int ZW   = $clog2(LAYERS);
  localparam int YW   = $clog2(ROWS_PER_LAYER);
  localparam int W    = CELLS_PER_ROW;

  l3dg_pkg::l3dg_state_t state_r, state_nxt;
  l3dg_pkg::l3dg_op_t    op;

  logic [AW-1:0] clr_addr_r, row_addr_r;
  logic [ZW-1:0] z_r;
  logic [YW-1:0] y_r;
  logic [1:0]    dz_r, dy_r;
  logic          bank_r, rd_ok_r;
  logic [7:0]    rate_r;
  logic          rd_valid_r, rd_center_r, rd_inr_r;
  logic          out_valid_r, out_stepped_r;
  logic [15:0]   out_bits_r;

  logic          accept, in_range;
  logic [AW-1:0] item_addr, nbr_addr;
  logic          nbr_inr, issue, lane_clear;
  logic          we, wbank, we_a, we_b;
  logic [AW-1:0] waddr, raddr;
  logic [W-1:0]  wdata, rdata_a, rdata_b, cur_rdata, lane_next;
  logic          rem_start, rem_done, rem_zero;
  logic [7:0]    divisor;
  logic          last_row;

  l3dg_pkg::l3dg_lane_ctl_t lane_ctl;

  assign busy      = (state_r != l3dg_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign op        = l3dg_pkg::l3dg_op_t'(in_operation);
  assign in_range  = (32'(in_layer) < LAYERS) && (32'(in_row) < ROWS_PER_LAYER);
  assign item_addr = AW'(32'(in_layer) * ROWS_PER_LAYER + 32'(in_row));
  assign divisor   = (rate_r == '0) ? 8'd1 : rate_r;
  assign last_row  = (row_addr_r == AW'(GRID - 1));
  assign cur_rdata = bank_r ? rdata_b : rdata_a;

  // no wrap: neighbors off the grid edge read as dead
  assign nbr_inr = !(dz_r == l3dg_pkg::D_LO && z_r == '0) &&
                   !(dz_r == l3dg_pkg::D_HI && z_r == ZW'(LAYERS - 1)) &&
                   !(dy_r == l3dg_pkg::D_LO && y_r == '0) &&
                   !(dy_r == l3dg_pkg::D_HI && y_r == YW'(ROWS_PER_LAYER - 1));
  assign nbr_addr = row_addr_r + AW'(32'(dz_r) * ROWS_PER_LAYER + 32'(dy_r))
                    - AW'(ROWS_PER_LAYER + 1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      l3dg_pkg::ST_CLEAR: begin
        if (clr_addr_r == AW'(GRID - 1)) state_nxt = l3dg_pkg::ST_IDLE;
      end
      l3dg_pkg::ST_IDLE: begin
        if (accept && op == l3dg_pkg::OP_READ) state_nxt = l3dg_pkg::ST_RDATA;
        else if (accept && op == l3dg_pkg::OP_TICK) state_nxt = l3dg_pkg::ST_MOD;
      end
      l3dg_pkg::ST_RDATA: state_nxt = l3dg_pkg::ST_IDLE;
      l3dg_pkg::ST_MOD: begin
        if (rem_done) state_nxt = rem_zero ? l3dg_pkg::ST_READ : l3dg_pkg::ST_IDLE;
      end
      l3dg_pkg::ST_READ: begin
        if (dz_r == l3dg_pkg::D_HI && dy_r == l3dg_pkg::D_HI) begin
          state_nxt = l3dg_pkg::ST_WAIT;
        end
      end
      l3dg_pkg::ST_WAIT:  state_nxt = l3dg_pkg::ST_WRITE;
      l3dg_pkg::ST_WRITE: state_nxt = last_row ? l3dg_pkg::ST_IDLE : l3dg_pkg::ST_READ;
      default:            state_nxt = l3dg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    we         = 1'b0;
    wbank      = bank_r;
    waddr      = row_addr_r;
    wdata      = lane_next;
    raddr      = nbr_addr;
    issue      = 1'b0;
    lane_clear = 1'b0;
    rem_start  = 1'b0;
    unique case (state_r)
      l3dg_pkg::ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr_r;
        wdata = '0;
      end
      l3dg_pkg::ST_IDLE: begin
        lane_clear = 1'b1;
        raddr      = item_addr;
        waddr      = item_addr;
        wdata      = in_row_bits[W-1:0];
        we         = accept && op == l3dg_pkg::OP_WRITE && in_range;
        rem_start  = accept && op == l3dg_pkg::OP_TICK;
      end
      l3dg_pkg::ST_READ: issue = 1'b1;
      l3dg_pkg::ST_WRITE: begin
        we         = 1'b1;
        wbank      = ~bank_r;
        lane_clear = 1'b1;
      end
      default: ;
    endcase
  end

  assign we_a = we && !wbank;
  assign we_b = we && wbank;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= l3dg_pkg::ST_CLEAR;
      clr_addr_r    <= '0;
      row_addr_r    <= '0;
      z_r           <= '0;
      y_r           <= '0;
      dz_r          <= l3dg_pkg::D_LO;
      dy_r          <= l3dg_pkg::D_LO;
      bank_r        <= 1'b0;
      rd_ok_r       <= 1'b0;
      rate_r        <= l3dg_pkg::RATE_RESET;
      rd_valid_r    <= 1'b0;
      rd_center_r   <= 1'b0;
      rd_inr_r      <= 1'b0;
      out_valid_r   <= 1'b0;
      out_stepped_r <= 1'b0;
      out_bits_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      rd_valid_r  <= issue;
      rd_center_r <= (dz_r == l3dg_pkg::D_MID) && (dy_r == l3dg_pkg::D_MID);
      rd_inr_r    <= nbr_inr;
      if (cfg_wr_en) rate_r <= cfg_wr_data;
      unique case (state_r)
        l3dg_pkg::ST_CLEAR: clr_addr_r <= clr_addr_r + AW'(1);
        l3dg_pkg::ST_IDLE: begin
          if (accept) begin
            rd_ok_r <= in_range;
            if (op == l3dg_pkg::OP_WRITE || op == l3dg_pkg::OP_NONE) begin
              out_valid_r   <= 1'b1;
              out_bits_r    <= '0;
              out_stepped_r <= 1'b0;
            end
          end
        end
        l3dg_pkg::ST_RDATA: begin
          out_valid_r   <= 1'b1;
          out_bits_r    <= rd_ok_r ? 16'(cur_rdata) : '0;
          out_stepped_r <= 1'b0;
        end
        l3dg_pkg::ST_MOD: begin
          if (rem_done) begin
            if (rem_zero) begin
              row_addr_r <= '0;
              z_r        <= '0;
              y_r        <= '0;
              dz_r       <= l3dg_pkg::D_LO;
              dy_r       <= l3dg_pkg::D_LO;
            end else begin
              out_valid_r   <= 1'b1;
              out_bits_r    <= '0;
              out_stepped_r <= 1'b0;
            end
          end
        end
        l3dg_pkg::ST_READ: begin
          if (dy_r == l3dg_pkg::D_HI) begin
            dy_r <= l3dg_pkg::D_LO;
            dz_r <= dz_r + 2'd1;
          end else begin
            dy_r <= dy_r + 2'd1;
          end
        end
        l3dg_pkg::ST_WRITE: begin
          dz_r <= l3dg_pkg::D_LO;
          dy_r <= l3dg_pkg::D_LO;
          if (last_row) begin
            bank_r        <= ~bank_r;
            out_valid_r   <= 1'b1;
            out_bits_r    <= '0;
            out_stepped_r <= 1'b1;
          end else begin
            row_addr_r <= row_addr_r + AW'(1);
            if (y_r == YW'(ROWS_PER_LAYER - 1)) begin
              y_r <= '0;
              z_r <= z_r + ZW'(1);
            end else begin
              y_r <= y_r + YW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign lane_ctl.clear  = lane_clear;
  assign lane_ctl.acc    = rd_valid_r;
  assign lane_ctl.center = rd_center_r;
  assign lane_ctl.inr    = rd_inr_r;

  l3dg_ram #(.WIDTH(W), .DEPTH(GRID)) u_bank_a (
    .clk(clk), .we(we_a), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata_a)
  );

  l3dg_ram #(.WIDTH(W), .DEPTH(GRID)) u_bank_b (
    .clk(clk), .we(we_b), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata_b)
  );

  l3dg_rem u_rem (
    .clk(clk), .rst_n(rst_n), .start(rem_start), .dividend(in_frame),
    .divisor(divisor), .done(rem_done), .zero(rem_zero)
  );

  l3dg_lanes #(.W(W)) u_lanes (
    .clk(clk), .ctl(lane_ctl), .data(cur_rdata), .next_row(lane_next)
  );

  assign out_valid     = out_valid_r;
  assign out_read_bits = out_bits_r;
  assign out_stepped   = out_stepped_r;

  // only one bank takes a write in any cycle
  a_one_bank_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(we_a && we_b)) else $error("both grid banks written at once");

  // banks swap only at the end of a generation, with the stepped result
  a_bank_swap: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && bank_r != $past(bank_r)) |-> (out_valid && out_stepped))
    else $error("bank swap without a completed generation");

  // count lanes never accumulate while a row is being written back
  a_no_acc_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == l3dg_pkg::ST_WRITE) |-> !rd_valid_r)
    else $error("neighbor data arrived during row write-back");

endmodule

>>> rtl/core/l3dg_ram.sv
// Generic single write port, single read port RAM with registered read.
module l3dg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/l3dg_rem.sv
// Bit-serial remainder unit: frame modulo update rate, one bit per cycle.
module l3dg_rem (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [l3dg_pkg::FRAME_W-1:0] dividend,
  input  logic [l3dg_pkg::RATE_W-1:0]  divisor,
  output logic                         done,
  output logic                         zero
);

  localparam int W = l3dg_pkg::FRAME_W;

  logic         run_r, done_r;
  logic [2:0]   cnt_r;
  logic [W-1:0] rem_r, dvd_r, div_r;
  logic [W:0]   trial;
  logic         ge;
  logic [W-1:0] step_rem;

  always_comb begin
    trial    = {rem_r, dvd_r[W-1]};
    ge       = trial >= {1'b0, div_r};
    step_rem = ge ? W'(trial - {1'b0, div_r}) : trial[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      div_r <= divisor;
    end else if (run_r) begin
      rem_r <= step_rem;
      dvd_r <= dvd_r << 1;
    end
  end

  assign done = done_r;
  assign zero = (rem_r == '0);

endmodule

>>> rtl/core/l3dg_lanes.sv
// Per-cell neighbor count lanes, fed one neighbor row per cycle while ctl.acc is high, plus the B3/S23 rule.
module l3dg_lanes #(
  parameter int W = 16
) (
  input  logic                     clk,
  input  l3dg_pkg::l3dg_lane_ctl_t ctl,
  input  logic [W-1:0]             data,
  output logic [W-1:0]             next_row
);

  localparam int CW = l3dg_pkg::CNT_W;

  logic [W-1:0]  d, lft, rgt;
  logic [CW-1:0] cnt_r [W];
  logic [W-1:0]  self_r;

  always_comb begin
    d   = ctl.inr ? data : '0;
    lft = d << 1;  // cell x sees cell x-1
    rgt = d >> 1;  // cell x sees cell x+1
  end

  always_ff @(posedge clk) begin
    for (int x = 0; x < W; x++) begin
      if (ctl.clear) begin
        cnt_r[x] <= '0;
      end else if (ctl.acc) begin
        cnt_r[x] <= cnt_r[x] + CW'(lft[x]) + CW'(rgt[x])
                    + (ctl.center ? CW'(0) : CW'(d[x]));
      end
    end
    if (ctl.acc && ctl.center) begin
      self_r <= d;
    end
  end

  always_comb begin
    for (int x = 0; x < W; x++) begin
      next_row[x] = (cnt_r[x] == l3dg_pkg::BORN_CNT) ||
                    (self_r[x] && (cnt_r[x] == l3dg_pkg::KEEP_CNT));
    end
  end

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the 3D life generation engine: row writes, reads and frame ticks.
module tb_top;

  typedef struct {
    logic [15:0] read_bits;
    logic        stepped;
  } life_result_t;

  // Tracks the grid and rate, and queues the result each accepted item should produce.
  class life_grid_board;
    logic [15:0]  cells [256];
    logic [7:0]   rate;
    life_result_t pending_q[$];
    int           errors;
    int           generations;
    int           nonzero_reads;

    function new();
      foreach (cells[i]) cells[i] = '0;
      rate = l3dg_pkg::RATE_RESET;
      errors = 0;
      generations = 0;
      nonzero_reads = 0;
    endfunction

    function void next_generation();
      logic [15:0] snap [256];
      int cnt;
      int nx, ny, nz;
      logic self_alive;
      logic [15:0] nrow;
      foreach (cells[i]) snap[i] = cells[i];
      for (int z = 0; z < 16; z++) begin
        for (int y = 0; y < 16; y++) begin
          nrow = '0;
          for (int x = 0; x < 16; x++) begin
            cnt = 0;
            for (int dz = -1; dz <= 1; dz++)
              for (int dy = -1; dy <= 1; dy++)
                for (int dx = -1; dx <= 1; dx++) begin
                  nx = x + dx; ny = y + dy; nz = z + dz;
                  if ((dx != 0 || dy != 0 || dz != 0) && nx >= 0 && nx < 16 &&
                      ny >= 0 && ny < 16 && nz >= 0 && nz < 16)
                    cnt += snap[nz*16 + ny][nx];
                end
            self_alive = snap[z*16 + y][x];
            nrow[x] = self_alive ? (cnt == 2 || cnt == 3) : (cnt == 3);
          end
          cells[z*16 + y] = nrow;
        end
      end
      generations++;
    endfunction

    function void note_item(l3dg_pkg::l3dg_op_t op, logic [3:0] layer, logic [3:0] row,
                            logic [15:0] bits, logic [7:0] frame);
      life_result_t r;
      int div;
      r.read_bits = '0;
      r.stepped = 1'b0;
      case (op)
        l3dg_pkg::OP_WRITE: cells[{layer, row}] = bits;
        l3dg_pkg::OP_READ: begin
          r.read_bits = cells[{layer, row}];
          if (r.read_bits != 0) nonzero_reads++;
        end
        l3dg_pkg::OP_TICK: begin
          div = (rate == 0) ? 1 : int'(rate);
          if (int'(frame) % div == 0) begin
            next_generation();
            r.stepped = 1'b1;
          end
        end
        default: ;
      endcase
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [15:0] read_bits, logic stepped);
      life_result_t exp_r;
      if (pending_q.size() == 0) begin
        $error("result with nothing outstanding: read_bits %h stepped %b", read_bits, stepped);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (read_bits !== exp_r.read_bits) begin
        $error("read_bits: expected %h actual %h", exp_r.read_bits, read_bits);
        errors++;
      end
      if (stepped !== exp_r.stepped) begin
        $error("stepped: expected %b actual %b", exp_r.stepped, stepped);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_operation;
  logic [3:0]  in_layer;
  logic [3:0]  in_row;
  logic [15:0] in_row_bits;
  logic [7:0]  in_frame;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        out_valid;
  logic [15:0] out_read_bits;
  logic        out_stepped;

  life_grid_board board;
  int  items_sent;
  bit  allow_gaps;

  life_3d_generation_engine_top dut (
    .clk, .rst_n, .start, .busy,
    .in_operation, .in_layer, .in_row, .in_row_bits, .in_frame,
    .cfg_wr_en, .cfg_wr_data,
    .out_valid, .out_read_bits, .out_stepped
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // accepted transfers and results, sampled at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy)
        board.note_item(l3dg_pkg::l3dg_op_t'(in_operation), in_layer, in_row,
                        in_row_bits, in_frame);
      if (out_valid)
        board.check_result(out_read_bits, out_stepped);
    end
  end

  task automatic send_item(l3dg_pkg::l3dg_op_t op, logic [3:0] layer, logic [3:0] row,
                           logic [15:0] bits, logic [7:0] frame);
    int gap;
    start <= 1'b1;
    in_operation <= op;
    in_layer <= layer;
    in_row <= row;
    in_row_bits <= bits;
    in_frame <= frame;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    items_sent++;
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    forever begin
      @(negedge clk);
      if (board.pending_q.size() == 0 && !busy) break;
    end
    @(posedge clk);
  endtask

  task automatic set_rate(logic [7:0] v);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.rate = v;
  endtask

  task automatic random_items(int count);
    int pick;
    logic [15:0] bits;
    logic [3:0] layer, row;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      // keep activity in a small block so structures live for a few generations
      if ($urandom_range(0, 3) != 0) begin
        layer = 4'($urandom_range(5, 8));
        row = 4'($urandom_range(5, 8));
      end else begin
        layer = 4'($urandom);
        row = 4'($urandom);
      end
      case ($urandom_range(0, 2))
        0: bits = 16'($urandom);
        1: bits = 16'($urandom) & 16'($urandom) & 16'($urandom);
        default: bits = 16'h0070 << $urandom_range(0, 9);
      endcase
      if (pick < 40)
        send_item(l3dg_pkg::OP_WRITE, layer, row, bits, 8'($urandom));
      else if (pick < 75)
        send_item(l3dg_pkg::OP_READ, layer, row, 16'($urandom), 8'($urandom));
      else if (pick < 95)
        send_item(l3dg_pkg::OP_TICK, layer, row, 16'($urandom), 8'($urandom));
      else
        send_item(l3dg_pkg::OP_NONE, layer, row, 16'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    board = new();
    items_sent = 0;
    allow_gaps = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = l3dg_pkg::OP_WRITE;
    in_layer = '0;
    in_row = '0;
    in_row_bits = '0;
    in_frame = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = l3dg_pkg::RATE_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: corner rows, extremes, unused opcode, stepping at rate 1
    send_item(l3dg_pkg::OP_READ, 4'd0, 4'd0, 16'hFFFF, 8'hFF);
    send_item(l3dg_pkg::OP_WRITE, 4'd0, 4'd0, 16'hFFFF, 8'h00);
    send_item(l3dg_pkg::OP_WRITE, 4'd15, 4'd15, 16'hFFFF, 8'hFF);
    send_item(l3dg_pkg::OP_WRITE, 4'd15, 4'd0, 16'h0000, 8'h00);
    send_item(l3dg_pkg::OP_READ, 4'd0, 4'd0, 16'h0000, 8'h00);
    send_item(l3dg_pkg::OP_READ, 4'd15, 4'd15, 16'h0000, 8'h00);
    send_item(l3dg_pkg::OP_NONE, 4'd15, 4'd15, 16'hFFFF, 8'hFF);
    send_item(l3dg_pkg::OP_WRITE, 4'd7, 4'd7, 16'h0380, 8'h00);
    send_item(l3dg_pkg::OP_WRITE, 4'd7, 4'd8, 16'h0380, 8'h00);
    send_item(l3dg_pkg::OP_TICK, 4'd0, 4'd0, 16'h0000, 8'h00);
    send_item(l3dg_pkg::OP_READ, 4'd7, 4'd7, 16'h0000, 8'h00);
    send_item(l3dg_pkg::OP_READ, 4'd0, 4'd0, 16'h0000, 8'h00);
    send_item(l3dg_pkg::OP_TICK, 4'd0, 4'd0, 16'h0000, 8'hFF);
    send_item(l3dg_pkg::OP_READ, 4'd7, 4'd8, 16'h0000, 8'h00);

    set_rate(8'd255);
    send_item(l3dg_pkg::OP_TICK, 4'd0, 4'd0, 16'h0000, 8'd254);
    send_item(l3dg_pkg::OP_TICK, 4'd0, 4'd0, 16'h0000, 8'd255);
    send_item(l3dg_pkg::OP_TICK, 4'd0, 4'd0, 16'h0000, 8'd0);
    send_item(l3dg_pkg::OP_READ, 4'd7, 4'd7, 16'h0000, 8'h00);

    allow_gaps = 1'b1;
    random_items(130);
    set_rate(8'd1);
    random_items(130);
    set_rate(8'd3);
    random_items(130);
    drain_results();
    set_rate(8'($urandom_range(2, 254)));
    random_items(80);
    allow_gaps = 1'b0;
    random_items(60);

    drain_results();
    repeat (30) @(posedge clk);
    $display("covered %0d items, %0d generations, %0d nonzero row reads",
             items_sent, board.generations, board.nonzero_reads);
    $display("update_rate settings included 1, 3, 255 and a random value");
    if (board.errors == 0 && board.pending_q.size() == 0)
      $display("life_3d_generation_engine_top regression: pass");
    else
      $display("life_3d_generation_engine_top regression: fail");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("life_3d_generation_engine_top regression: fail");
    $finish;
  end

endmodule
